### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### sv/cidt_pkg.sv
package cidt_pkg;

    // identifier length accepted by insert and erase
    localparam logic [7:0] ID_BYTES = 8'd4;

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    // request item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] device_id;
        logic [7:0]  id_length;
    } t_req;

    // result item
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_rsp;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### sv/cidt_cell.sv
module cidt_cell (
    input  logic                 i_clk,
    input  cidt_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_live,
    input  logic [31:0]          i_key,
    input  logic [31:0]          i_next,
    output logic [31:0]          o_entry,
    output logic                 o_hit
);

    logic [31:0] r_entry;
    logic [31:0] n_entry;
    logic        r_hit;

    // entry update: load the key, take the upper neighbor's entry, or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_key;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // compare against the key while this slot holds a valid entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= i_live && (r_entry == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

### sv/cidt_sel.sv
module cidt_sel #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [DEPTH-1:0]         i_hit,
    output logic                     o_any,
    output logic [DEPTH-1:0]         o_ge,
    output logic [$clog2(DEPTH)-1:0] o_pos
);

    localparam int PW = $clog2(DEPTH);

    logic [DEPTH-1:0] w_ge;
    logic [DEPTH-1:0] w_first;
    logic [PW-1:0]    w_pos;
    logic [DEPTH-1:0] r_ge;
    logic [PW-1:0]    r_pos;
    logic             r_any;

    // prefix or by doubling: slots at or above the first hit
    always_comb begin
        w_ge = i_hit;
        for (int k = 0; k < PW; k++) begin
            w_ge = w_ge | (w_ge << (1 << k));
        end
    end

    // one-hot first hit and its index
    always_comb begin
        w_first = w_ge & ~(w_ge << 1);
        w_pos   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ge  <= w_ge;
            r_pos <= w_pos;
            r_any <= |i_hit;
        end
    end

    assign o_any = r_any;
    assign o_ge  = r_ge;
    assign o_pos = r_pos;

endmodule

### sv/compacted_id_table_top.sv
// compacted device-id table
// keeps a gap-free list of up to DEPTH 32-bit ids in a row of cells plus
// an entry count. requests come in on i_in_* (valid/ready), results leave
// on o_out_* (valid/ready), one result per request.
// insert appends a new id, erase removes the first match and every later
// cell takes its upper neighbor's entry, lookup reports the first match.
// sequence: a request is taken in the idle state; the compare state
// compares the key in every cell, the select state picks the first hit,
// the update state commits the update and loads the result register. the
// next request can be taken once the sequencer is back in idle, so a new
// request is not taken before the last one is through.
// if the result register still holds an untaken result, the commit waits
// in its final step until the receiver takes it; the table does not
// change until then.
// reset empties the table (count zero) and drops any pending result; cell
// contents are left as they are and never read until rewritten.
module compacted_id_table_top #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cidt_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cidt_pkg::t_rsp   o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    cidt_pkg::t_req       r_req;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    cidt_pkg::t_rsp       r_out;
    cidt_pkg::t_rsp       n_out;

    logic                 w_in_xfer;
    logic                 w_commit;
    logic                 w_do_insert;
    logic                 w_do_erase;
    logic                 w_full;
    logic                 w_len_ok;
    logic [1:0]           w_status;
    logic                 w_report_pos;

    logic [DEPTH-1:0]     w_hit;
    logic [DEPTH-1:0]     w_ge;
    logic                 w_any;
    logic [PW-1:0]        w_pos;
    logic [31:0]          w_entry [DEPTH];
    cidt_pkg::t_cell_ctl  w_ctl [DEPTH];
    logic [DEPTH-1:0]     w_live;

    logic [PW+3:0]        w_pos_ext;
    logic [CW+4:0]        w_count_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = S_UPD;
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req <= i_in_data;
        end
    end

    // request decode once the first hit is known
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_len_ok = (r_req.id_length == cidt_pkg::ID_BYTES);

    always_comb begin
        w_do_insert  = 1'b0;
        w_do_erase   = 1'b0;
        w_report_pos = 1'b0;
        w_status     = cidt_pkg::ST_ERROR;
        case (r_req.req_type)
            cidt_pkg::REQ_INSERT: begin
                if (w_any) begin
                    w_status = cidt_pkg::ST_PRESENT;
                end else if (w_full || !w_len_ok) begin
                    w_status = cidt_pkg::ST_ERROR;
                end else begin
                    w_status    = cidt_pkg::ST_OK;
                    w_do_insert = 1'b1;
                end
            end
            cidt_pkg::REQ_ERASE: begin
                if (!w_any) begin
                    w_status = cidt_pkg::ST_NOTFOUND;
                end else if (!w_len_ok) begin
                    w_status = cidt_pkg::ST_ERROR;
                end else begin
                    w_status   = cidt_pkg::ST_OK;
                    w_do_erase = 1'b1;
                end
            end
            cidt_pkg::REQ_LOOKUP: begin
                if (w_any) begin
                    w_status     = cidt_pkg::ST_OK;
                    w_report_pos = 1'b1;
                end else begin
                    w_status = cidt_pkg::ST_NOTFOUND;
                end
            end
            default: w_status = cidt_pkg::ST_ERROR;
        endcase
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (w_commit && w_do_insert) begin
            n_count = r_count + CW'(1);
        end else if (w_commit && w_do_erase) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // row of cells, each fed by its upper neighbor; the last cell is fed by its own entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_live[g]      = (CW'(g) < r_count);
        assign w_ctl[g].cmp   = (r_state == S_CMP);
        assign w_ctl[g].load  = w_commit && w_do_insert && (CW'(g) == r_count);
        assign w_ctl[g].shift = w_commit && w_do_erase && w_ge[g] && (CW'(g + 1) < r_count);

        if (g == DEPTH - 1) begin : g_last
            cidt_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_live  (w_live[g]),
                .i_key   (r_req.device_id),
                .i_next  (w_entry[g]),
                .o_entry (w_entry[g]),
                .o_hit   (w_hit[g])
            );
        end else begin : g_mid
            cidt_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_live  (w_live[g]),
                .i_key   (r_req.device_id),
                .i_next  (w_entry[g + 1]),
                .o_entry (w_entry[g]),
                .o_hit   (w_hit[g])
            );
        end
    end

    // first-hit select
    cidt_sel #(
        .DEPTH (DEPTH)
    ) u_sel (
        .i_clk (i_clk),
        .i_en  (r_state == S_SEL),
        .i_hit (w_hit),
        .o_any (w_any),
        .o_ge  (w_ge),
        .o_pos (w_pos)
    );

    // result assembly
    assign w_pos_ext   = {4'b0, w_pos};
    assign w_count_ext = {5'b0, n_count};

    always_comb begin
        n_out.status      = w_status;
        n_out.position    = w_report_pos ? w_pos_ext[3:0] : 4'd0;
        n_out.entry_count = w_count_ext[4:0];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sv/cidt_checker.sv
`include "assert_macros.svh"

module cidt_checker #(
    parameter int DEPTH = 16
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input cidt_pkg::t_rsp  o_out_data
);

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    property p_out_hold;
        w_out_stall |=> o_out_valid && $stable(o_out_data);
    endproperty

    property p_pos_ok;
        o_out_valid && (o_out_data.position != 4'd0) |-> o_out_data.status == cidt_pkg::ST_OK;
    endproperty

    property p_count_max;
        o_out_valid |-> (DEPTH > 31) || (o_out_data.entry_count <= DEPTH);
    endproperty

    // a pending result stays until taken
    `ASSERT_STD(a_out_hold, p_out_hold, "result dropped or changed while stalled")

    // one request at a time: busy right after a request transfer
    `ASSERT_STD(a_busy_after_req, w_in_xfer |=> !o_in_ready, "request taken while busy")

    // result valid once the request has passed the compare, select and update states
    `ASSERT_STD(a_latency, w_in_xfer |-> ##4 o_out_valid, "result missing after request")

    // only a successful lookup reports a nonzero position
    `ASSERT_STD(a_pos_ok, p_pos_ok, "position set on failed request")

    // the count never exceeds the table size
    `ASSERT_STD(a_count_max, p_count_max, "entry count above table size")

endmodule

bind compacted_id_table_top cidt_checker #(.DEPTH(DEPTH)) u_cidt_checker (.*);
